FILE: rtl/core/dpas_pkg.sv
`timescale 1ns / 1ps
package dpas_pkg;

	localparam int TAB_LEN = 24;
	localparam int TAB_IDX_W = 5;
	localparam int XY_W = 35;
	localparam int Z_W = 29;
	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 33;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = 52;
	localparam logic signed [Z_W-1:0] PI_Q24 = 29'sd52707179;

	localparam logic [2:0] REG_SPEED_P = 3'd0;
	localparam logic [2:0] REG_SPEED_I = 3'd1;
	localparam logic [2:0] REG_SPEED_D = 3'd2;
	localparam logic [2:0] REG_STEER_P = 3'd3;
	localparam logic [2:0] REG_STEER_I = 3'd4;
	localparam logic [2:0] REG_STEER_D = 3'd5;
	localparam logic [2:0] REG_AXLE = 3'd6;

	// control of the shared multiplier
	typedef struct packed {
		logic mul;  // register a*b
		logic acc;  // add registered product into accumulator
		logic clr;  // with acc: load product instead of adding
	} mac_ctl_t;

	// atan(2^-i) in Q.24
	function automatic logic signed [Z_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] i);
		logic signed [Z_W-1:0] r;
		begin
			case (i)
				5'd0: r = 29'sd13176795;
				5'd1: r = 29'sd7778716;
				5'd2: r = 29'sd4110060;
				5'd3: r = 29'sd2086331;
				5'd4: r = 29'sd1047214;
				5'd5: r = 29'sd524117;
				5'd6: r = 29'sd262123;
				5'd7: r = 29'sd131069;
				5'd8: r = 29'sd65536;
				5'd9: r = 29'sd32768;
				5'd10: r = 29'sd16384;
				5'd11: r = 29'sd8192;
				5'd12: r = 29'sd4096;
				5'd13: r = 29'sd2048;
				5'd14: r = 29'sd1024;
				5'd15: r = 29'sd512;
				5'd16: r = 29'sd256;
				5'd17: r = 29'sd128;
				5'd18: r = 29'sd64;
				5'd19: r = 29'sd32;
				5'd20: r = 29'sd16;
				5'd21: r = 29'sd8;
				5'd22: r = 29'sd4;
				5'd23: r = 29'sd2;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

FILE: rtl/core/dual_pid_ackermann_steer_top.sv
`timescale 1ns / 1ps
// Two discrete PID loops for a car with Ackermann steering. A word with tuser 0 is a
// command: it stores the target speed and the target steering angle atan(L*omega/v)
// (zero when v or omega is zero) and gives no output word. A word with tuser 1 is
// odometry: the measured steering angle atan2(yaw*L, v) (zero when v is zero) is found,
// then the speed loop and the steering loop run and one output word carries the speed
// drive and the negated steering drive, each saturated to 16 bits. Gains are Q3.12,
// speeds Q7.8, angles Q3.12. An odometry word goes through the idle state that takes it,
// the y = omega*L product, the iterative CORDIC (one rotation per cycle), each loop on one
// shared 16x33 multiplier (three products per loop) and the load of the output register.
// A command word ends after the CORDIC; a command with zero speed or rate and odometry
// with zero speed skip the CORDIC. The output load also waits while the previous output
// word is still unaccepted. s_tready is high only while the sequencer is idle; a finished
// output word waits in its register while the next item is taken. Write the registers
// through cfg_we/cfg_addr/cfg_data only while idle; the block itself does not enforce this.
module dual_pid_ackermann_steer_top #(
	parameter int CORDIC_STEPS = 14,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // linear_velocity[15:0], angular_velocity[31:16]
	input  logic s_tuser,         // req_type
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata,  // speed_drive[15:0], steer_drive[31:16]
	input  logic cfg_we,
	input  logic [2:0] cfg_addr,
	input  logic [15:0] cfg_data
);
	import dpas_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_YMUL = 4'd1;
	localparam logic [3:0] ST_YACC = 4'd2;
	localparam logic [3:0] ST_CWAIT = 4'd3;
	localparam logic [3:0] ST_PE = 4'd4;
	localparam logic [3:0] ST_M0 = 4'd5;
	localparam logic [3:0] ST_M1 = 4'd6;
	localparam logic [3:0] ST_M2 = 4'd7;
	localparam logic [3:0] ST_M3 = 4'd8;
	localparam logic [3:0] ST_RND = 4'd9;
	localparam logic [3:0] ST_OUT = 4'd10;

	// configuration
	logic signed [15:0] kp_q [2];
	logic signed [15:0] ki_q [2];
	logic signed [15:0] kd_q [2];
	logic [15:0] axle_q;

	// controller state
	logic [3:0] state_q;
	logic odo_q;
	logic lp_q;  // 0 speed loop, 1 steering loop
	logic signed [15:0] v_q, w_q;
	logic signed [15:0] tgt_speed_q, tgt_angle_q, meas_q;
	logic signed [31:0] sum_q [2];
	logic signed [16:0] last_q [2];
	logic signed [16:0] e_q;
	logic signed [31:0] sumn_q;
	logic signed [17:0] diff_q;
	logic signed [15:0] spd_res_q;
	logic m_valid_q;
	logic [31:0] m_data_q;
	logic out_load;

	// shared units
	mac_ctl_t mctl;
	logic signed [MUL_A_W-1:0] ma;
	logic signed [MUL_B_W-1:0] mb;
	logic signed [ACC_W-1:0] acc;
	logic c_start, c_done;
	logic c_go_q;
	logic signed [XY_W-1:0] cx, cy;
	logic signed [15:0] c_angle;

	// loop arithmetic
	logic signed [16:0] tgt_sel, meas_sel, e_new;
	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_new;
	logic signed [17:0] diff_new;
	logic signed [ACC_W:0] acc_n, acc_r;
	logic signed [15:0] res16;
	logic zero_ang;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	dpas_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mctl), .a(ma), .b(mb), .acc(acc)
	);

	dpas_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .fold(!odo_q),
		.x0(cx), .y0(cy), .done(c_done), .angle(c_angle)
	);

	// x = v * 4096, y = omega * L from the multiplier
	assign cx = XY_W'(v_q) <<< 12;
	assign cy = XY_W'($signed(acc[31:0]));
	assign zero_ang = (v_q == 16'sd0) || (!odo_q && w_q == 16'sd0);
	// degenerate vectors skip the CORDIC so it never runs in the background
	assign c_start = c_go_q && !zero_ang;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_comb begin
		mctl = '0;
		ma = '0;
		mb = '0;
		case (state_q)
			ST_YMUL: begin
				mctl.mul = 1'b1;
				ma = w_q;
				mb = MUL_B_W'($signed({1'b0, axle_q}));
			end
			ST_YACC: begin
				mctl.acc = 1'b1;
				mctl.clr = 1'b1;
			end
			ST_M0: begin
				mctl.mul = 1'b1;
				ma = kp_q[lp_q];
				mb = MUL_B_W'(e_q);
			end
			ST_M1: begin
				mctl.mul = 1'b1;
				mctl.acc = 1'b1;
				mctl.clr = 1'b1;
				ma = ki_q[lp_q];
				mb = MUL_B_W'(sumn_q);
			end
			ST_M2: begin
				mctl.mul = 1'b1;
				mctl.acc = 1'b1;
				ma = kd_q[lp_q];
				mb = MUL_B_W'(diff_q);
			end
			ST_M3: mctl.acc = 1'b1;
			default: mctl = '0;
		endcase
	end

	always_comb begin
		tgt_sel = lp_q ? 17'(tgt_angle_q) : 17'(tgt_speed_q);
		meas_sel = lp_q ? 17'(meas_q) : 17'(v_q);
		e_new = tgt_sel - meas_sel;
		sum_ext = 33'(sum_q[lp_q]) + 33'(e_new);
		if (sum_ext > 33'sh0_7FFF_FFFF)
			sum_new = 32'sh7FFF_FFFF;
		else if (sum_ext < -33'sh0_8000_0000)
			sum_new = 32'sh8000_0000;
		else
			sum_new = sum_ext[31:0];
		diff_new = 18'(e_new) - 18'(last_q[lp_q]);
		acc_n = lp_q ? -(ACC_W+1)'(acc) : (ACC_W+1)'(acc);
		acc_r = (acc_n + ((ACC_W+1)'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
		if (acc_r > (ACC_W+1)'(32767))
			res16 = 16'sh7FFF;
		else if (acc_r < -(ACC_W+1)'(32768))
			res16 = 16'sh8000;
		else
			res16 = acc_r[15:0];
	end

	// cordic starts in the cycle after the y product lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			c_go_q <= 1'b0;
		else
			c_go_q <= (state_q == ST_YACC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q[0] <= 16'sd7209;
			ki_q[0] <= 16'sd0;
			kd_q[0] <= 16'sd41;
			kp_q[1] <= 16'sd7127;
			ki_q[1] <= 16'sd0;
			kd_q[1] <= 16'sd41;
			axle_q <= 16'd12288;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SPEED_P: kp_q[0] <= cfg_data;
				REG_SPEED_I: ki_q[0] <= cfg_data;
				REG_SPEED_D: kd_q[0] <= cfg_data;
				REG_STEER_P: kp_q[1] <= cfg_data;
				REG_STEER_I: ki_q[1] <= cfg_data;
				REG_STEER_D: kd_q[1] <= cfg_data;
				REG_AXLE: axle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output valid: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			odo_q <= 1'b0;
			lp_q <= 1'b0;
			tgt_speed_q <= '0;
			tgt_angle_q <= '0;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			last_q[0] <= '0;
			last_q[1] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						odo_q <= s_tuser;
						v_q <= s_tdata[15:0];
						w_q <= s_tdata[31:16];
						state_q <= ST_YMUL;
					end
				end
				ST_YMUL: state_q <= ST_YACC;
				ST_YACC: state_q <= ST_CWAIT;
				ST_CWAIT: begin
					if (c_go_q && zero_ang) begin
						// degenerate vector: angle is zero, no rotation needed
						if (odo_q) begin
							meas_q <= '0;
							lp_q <= 1'b0;
							state_q <= ST_PE;
						end else begin
							tgt_speed_q <= v_q;
							tgt_angle_q <= '0;
							state_q <= ST_IDLE;
						end
					end else if (c_done) begin
						if (odo_q) begin
							meas_q <= c_angle;
							lp_q <= 1'b0;
							state_q <= ST_PE;
						end else begin
							tgt_speed_q <= v_q;
							tgt_angle_q <= c_angle;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PE: begin
					e_q <= e_new;
					sumn_q <= sum_new;
					diff_q <= diff_new;
					sum_q[lp_q] <= sum_new;
					last_q[lp_q] <= e_new;
					state_q <= ST_M0;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_RND;
				ST_RND: begin
					if (!lp_q) begin
						spd_res_q <= res16;
						lp_q <= 1'b1;
						state_q <= ST_PE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// accumulator still holds the steering sum here
					if (out_load) begin
						m_data_q <= {res16, spd_res_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/dpas_cordic.sv
`timescale 1ns / 1ps
module dpas_cordic #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic fold,  // fold left half plane without adding pi
	input  logic signed [dpas_pkg::XY_W-1:0] x0,
	input  logic signed [dpas_pkg::XY_W-1:0] y0,
	output logic done,
	output logic signed [15:0] angle
);
	import dpas_pkg::*;

	localparam logic [TAB_IDX_W-1:0] LAST = TAB_IDX_W'(CORDIC_STEPS);

	logic busy_q;
	logic [TAB_IDX_W-1:0] cnt_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W:0] zr;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign done = busy_q && (cnt_q == LAST);
	assign zr = {z_q[Z_W-1], z_q} + (Z_W+1)'(2048);
	assign angle = zr[27:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x0 < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				if (fold)
					z_q <= '0;
				else
					z_q <= (y0 >= 0) ? PI_Q24 : -PI_Q24;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q && cnt_q != LAST) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_q24(cnt_q);
			end else if (y_q < 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_q24(cnt_q);
			end
		end
	end
endmodule

FILE: rtl/core/dpas_mac.sv
`timescale 1ns / 1ps
module dpas_mac (
	input  logic clk,
	input  logic arst_n,
	input  dpas_pkg::mac_ctl_t ctl,
	input  logic signed [dpas_pkg::MUL_A_W-1:0] a,
	input  logic signed [dpas_pkg::MUL_B_W-1:0] b,
	output logic signed [dpas_pkg::ACC_W-1:0] acc
);
	import dpas_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			if (ctl.clr)
				acc_q <= ACC_W'(prod_q);
			else
				acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul)
			prod_q <= a * b;
	end
endmodule
